// ----- hw/rtl/ibp_pkg.sv -----
package ibp_pkg;

    // Registers arrive as unsigned Q1.16 values.
    localparam int REG_FRAC = 16;
    localparam int REG_W    = 17;
    localparam int CH_W     = 8;

    localparam logic [REG_W-1:0] REG_RESET = 17'h10000;
    localparam logic [CH_W-1:0]  CH_MAX    = 8'hFF;

    typedef enum logic {
        CFG_ILLUM_MIN = 1'b0,
        CFG_ILLUM_MAX = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pix;

    // Stage control that travels with every pixel.
    typedef struct packed {
        logic valid;
        logic bright;
        logic ovf;
    } t_ctl;

endpackage

// ----- hw/rtl/ibp_front.sv -----
module ibp_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  ibp_pkg::t_pix                      i_pix,
    input  logic [ibp_pkg::CH_W-1:0]           i_light,
    input  logic [ibp_pkg::REG_W-1:0]          i_illum_min,
    input  logic [ibp_pkg::REG_W-1:0]          i_illum_max,
    input  logic                               i_ready,
    output logic                               o_ready,
    output ibp_pkg::t_ctl                      o_ctl,
    output ibp_pkg::t_pix                      o_pix,
    output logic [2*FRAC_BITS:0]               o_num,
    output logic [FRAC_BITS:0]                 o_div
);

    localparam int IW    = FRAC_BITS + 1;
    localparam int NW    = 2 * FRAC_BITS + 1;
    localparam int QW    = FRAC_BITS + 8;
    localparam int CW    = IW + QW;
    localparam int A_DIV = (1 << FRAC_BITS) / 255;
    localparam int B_MOD = (1 << FRAC_BITS) % 255;
    localparam int K4    = (4 * (1 << FRAC_BITS) + 5) / 10;

    localparam logic [IW-1:0] A_DIV_C = IW'(A_DIV);
    localparam logic [15:0]   B_MOD_C = 16'(B_MOD);
    localparam logic [NW-1:0] K4_C    = NW'(K4);

    logic [IW-1:0] lo;
    logic [IW-1:0] hi;

    generate
        if (FRAC_BITS >= ibp_pkg::REG_FRAC) begin : g_up
            assign lo = IW'(i_illum_min) << (FRAC_BITS - ibp_pkg::REG_FRAC);
            assign hi = IW'(i_illum_max) << (FRAC_BITS - ibp_pkg::REG_FRAC);
        end else begin : g_down
            assign lo = IW'(i_illum_min >> (ibp_pkg::REG_FRAC - FRAC_BITS));
            assign hi = IW'(i_illum_max >> (ibp_pkg::REG_FRAC - FRAC_BITS));
        end
    endgenerate

    // light * 2^F / 255 is split as light * (2^F div 255) plus the floor of
    // light * (2^F mod 255) / 255, and the latter fits the 16-bit trick.
    logic [15:0]   lb;
    logic [16:0]   lb_sum;
    logic [IW-1:0] n_illum;
    logic [NW-1:0] n_num;

    always_comb begin
        lb      = 16'(i_light) * B_MOD_C;
        lb_sum  = {1'b0, lb} + 17'd1 + {9'd0, lb[15:8]};
        n_illum = IW'(i_light) * A_DIV_C + IW'(lb_sum[16:8]);
        n_num   = K4_C * NW'(hi);
    end

    ibp_pkg::t_ctl r_a_ctl;
    ibp_pkg::t_pix r_a_pix;
    logic [IW-1:0] r_a_illum;
    logic [NW-1:0] r_a_num;

    ibp_pkg::t_ctl r_b_ctl;
    ibp_pkg::t_pix r_b_pix;
    logic [NW-1:0] r_b_num;
    logic [IW-1:0] r_b_div;

    logic a_ready;
    logic b_ready;

    assign b_ready = !r_b_ctl.valid || i_ready;
    assign a_ready = !r_a_ctl.valid || b_ready;
    assign o_ready = a_ready;

    logic [IW-1:0] clamped;
    ibp_pkg::t_ctl n_b_ctl;
    logic [IW-1:0] n_b_div;

    always_comb begin
        clamped        = (r_a_illum < lo) ? lo : r_a_illum;
        n_b_div        = (clamped == '0) ? IW'(1) : clamped;
        n_b_ctl.valid  = r_a_ctl.valid;
        n_b_ctl.bright = clamped < hi;
        // A quotient that does not fit saturates every nonzero channel.
        n_b_ctl.ovf    = CW'(r_a_num) >= (CW'(n_b_div) << QW);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_b_ctl <= '0;
        end else begin
            if (a_ready) begin
                r_a_ctl <= '{valid: i_valid, bright: 1'b0, ovf: 1'b0};
            end
            if (b_ready) begin
                r_b_ctl <= n_b_ctl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready) begin
            r_a_pix   <= i_pix;
            r_a_illum <= n_illum;
            r_a_num   <= n_num;
        end
        if (b_ready) begin
            r_b_pix <= r_a_pix;
            r_b_num <= r_a_num;
            r_b_div <= n_b_div;
        end
    end

    assign o_ctl = r_b_ctl;
    assign o_pix = r_b_pix;
    assign o_num = r_b_num;
    assign o_div = r_b_div;

endmodule

// ----- hw/rtl/ibp_div_step.sv -----
module ibp_div_step #(
    parameter int FRAC_BITS = 16,
    parameter int BIT       = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ibp_pkg::t_ctl            i_ctl,
    input  ibp_pkg::t_pix            i_pix,
    input  logic [2*FRAC_BITS:0]     i_rem,
    input  logic [FRAC_BITS:0]       i_div,
    input  logic [FRAC_BITS+7:0]     i_quo,
    input  logic                     i_ready,
    output logic                     o_ready,
    output ibp_pkg::t_ctl            o_ctl,
    output ibp_pkg::t_pix            o_pix,
    output logic [2*FRAC_BITS:0]     o_rem,
    output logic [FRAC_BITS:0]       o_div,
    output logic [FRAC_BITS+7:0]     o_quo
);

    localparam int IW = FRAC_BITS + 1;
    localparam int NW = 2 * FRAC_BITS + 1;
    localparam int QW = FRAC_BITS + 8;
    localparam int CW = IW + QW;

    logic [CW-1:0] shifted;
    logic          ge;
    logic [NW-1:0] n_rem;
    logic [QW-1:0] n_quo;

    // One restoring step: try to take divisor * 2^BIT out of the remainder.
    always_comb begin
        shifted = CW'(i_div) << BIT;
        ge      = CW'(i_rem) >= shifted;
        n_rem   = ge ? NW'(CW'(i_rem) - shifted) : i_rem;
        n_quo   = ge ? (i_quo | (QW'(1) << BIT)) : i_quo;
    end

    ibp_pkg::t_ctl r_ctl;
    ibp_pkg::t_pix r_pix;
    logic [NW-1:0] r_rem;
    logic [IW-1:0] r_div;
    logic [QW-1:0] r_quo;

    assign o_ready = !r_ctl.valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (o_ready) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_pix <= i_pix;
            r_rem <= n_rem;
            r_div <= i_div;
            r_quo <= n_quo;
        end
    end

    assign o_ctl = r_ctl;
    assign o_pix = r_pix;
    assign o_rem = r_rem;
    assign o_div = r_div;
    assign o_quo = r_quo;

endmodule

// ----- hw/rtl/ibp_back.sv -----
module ibp_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ibp_pkg::t_ctl        i_ctl,
    input  ibp_pkg::t_pix        i_pix,
    input  logic [FRAC_BITS+7:0] i_quo,
    input  logic                 i_ready,
    output logic                 o_ready,
    output logic                 o_valid,
    output ibp_pkg::t_pix        o_pix
);

    localparam int QW = FRAC_BITS + 8;
    localparam int SW = FRAC_BITS + 9;
    localparam int PW = SW + ibp_pkg::CH_W;
    localparam int K6 = (6 * (1 << FRAC_BITS) + 5) / 10;

    localparam logic [SW-1:0] K6_C  = SW'(K6);
    localparam logic [SW-1:0] SAT_C = SW'(1) << QW;

    function automatic logic [ibp_pkg::CH_W-1:0] scale_ch(
        input logic [ibp_pkg::CH_W-1:0] ch,
        input logic [SW-1:0]            scale
    );
        logic [PW-1:0] prod;
        prod = PW'(ch) * PW'(scale);
        if (|prod[PW-1:FRAC_BITS+8]) begin
            scale_ch = ibp_pkg::CH_MAX;
        end else begin
            scale_ch = prod[FRAC_BITS+7:FRAC_BITS];
        end
    endfunction

    ibp_pkg::t_ctl r_s_ctl;
    ibp_pkg::t_pix r_s_pix;
    logic [SW-1:0] r_s_scale;

    logic          r_o_valid;
    ibp_pkg::t_pix r_o_pix;

    logic s_ready;
    logic out_ready;

    assign out_ready = !r_o_valid || i_ready;
    assign s_ready   = !r_s_ctl.valid || out_ready;
    assign o_ready   = s_ready;

    logic [SW-1:0] n_scale;
    ibp_pkg::t_pix n_pix;

    always_comb begin
        n_scale = i_ctl.ovf ? SAT_C : K6_C + SW'(i_quo);
        if (r_s_ctl.bright) begin
            n_pix.red   = scale_ch(r_s_pix.red, r_s_scale);
            n_pix.green = scale_ch(r_s_pix.green, r_s_scale);
            n_pix.blue  = scale_ch(r_s_pix.blue, r_s_scale);
        end else begin
            n_pix = r_s_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_ctl   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (s_ready) begin
                r_s_ctl <= i_ctl;
            end
            if (out_ready) begin
                r_o_valid <= r_s_ctl.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ready) begin
            r_s_pix   <= i_pix;
            r_s_scale <= n_scale;
        end
        if (out_ready) begin
            r_o_pix <= n_pix;
        end
    end

    assign o_valid = r_o_valid;
    assign o_pix   = r_o_pix;

endmodule

// ----- hw/rtl/illumination_brighten_pixel.sv -----
// Channel   Direction  Handshake          Payload
// pixel in  input      i_valid / o_stall  i_red_in, i_green_in, i_blue_in, i_light_level
// pixel out output     o_valid / i_stall  o_red_out, o_green_out, o_blue_out
// config    input      i_cfg_wr_en        i_cfg_index, i_cfg_wdata (17 bits)
//
// One pixel per clock while i_stall is low; the divider resolves one quotient
// bit per stage over FRAC_BITS + 8 stages.
// Synchronous active-low reset empties the pipeline and sets both registers to 1.0.
// A stall holds only the stages that are full: bubbles close up, so the
// pipeline keeps taking pixels until every stage holds one.
module illumination_brighten_pixel #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [ibp_pkg::CH_W-1:0]         i_red_in,
    input  logic [ibp_pkg::CH_W-1:0]         i_green_in,
    input  logic [ibp_pkg::CH_W-1:0]         i_blue_in,
    input  logic [ibp_pkg::CH_W-1:0]         i_light_level,
    input  logic                             i_cfg_wr_en,
    input  logic                             i_cfg_index,
    input  logic [ibp_pkg::REG_W-1:0]        i_cfg_wdata,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [ibp_pkg::CH_W-1:0]         o_red_out,
    output logic [ibp_pkg::CH_W-1:0]         o_green_out,
    output logic [ibp_pkg::CH_W-1:0]         o_blue_out
);

    localparam int IW = FRAC_BITS + 1;
    localparam int NW = 2 * FRAC_BITS + 1;
    localparam int QW = FRAC_BITS + 8;

    logic [ibp_pkg::REG_W-1:0] r_illum_min;
    logic [ibp_pkg::REG_W-1:0] r_illum_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_illum_min <= ibp_pkg::REG_RESET;
            r_illum_max <= ibp_pkg::REG_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (ibp_pkg::t_cfg_idx'(i_cfg_index))
                ibp_pkg::CFG_ILLUM_MIN: r_illum_min <= i_cfg_wdata;
                ibp_pkg::CFG_ILLUM_MAX: r_illum_max <= i_cfg_wdata;
            endcase
        end
    end

    ibp_pkg::t_pix in_pix;
    assign in_pix = '{red: i_red_in, green: i_green_in, blue: i_blue_in};

    ibp_pkg::t_ctl div_ctl [0:QW];
    ibp_pkg::t_pix div_pix [0:QW];
    logic [NW-1:0] div_rem [0:QW];
    logic [IW-1:0] div_d   [0:QW];
    logic [QW-1:0] div_quo [0:QW];
    logic          div_rdy [0:QW];
    logic          front_ready;

    assign div_quo[0] = '0;

    ibp_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_pix       (in_pix),
        .i_light     (i_light_level),
        .i_illum_min (r_illum_min),
        .i_illum_max (r_illum_max),
        .i_ready     (div_rdy[0]),
        .o_ready     (front_ready),
        .o_ctl       (div_ctl[0]),
        .o_pix       (div_pix[0]),
        .o_num       (div_rem[0]),
        .o_div       (div_d[0])
    );

    // Most significant quotient bit first.
    generate
        for (genvar s = 0; s < QW; s++) begin : g_div
            ibp_div_step #(
                .FRAC_BITS(FRAC_BITS),
                .BIT      (QW - 1 - s)
            ) u_step (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (div_ctl[s]),
                .i_pix   (div_pix[s]),
                .i_rem   (div_rem[s]),
                .i_div   (div_d[s]),
                .i_quo   (div_quo[s]),
                .i_ready (div_rdy[s+1]),
                .o_ready (div_rdy[s]),
                .o_ctl   (div_ctl[s+1]),
                .o_pix   (div_pix[s+1]),
                .o_rem   (div_rem[s+1]),
                .o_div   (div_d[s+1]),
                .o_quo   (div_quo[s+1])
            );
        end
    endgenerate

    ibp_pkg::t_pix out_pix;

    ibp_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl[QW]),
        .i_pix   (div_pix[QW]),
        .i_quo   (div_quo[QW]),
        .i_ready (!i_stall),
        .o_ready (div_rdy[QW]),
        .o_valid (o_valid),
        .o_pix   (out_pix)
    );

    // The final remainder and divisor are not needed past the last step.
    logic unused_tail;
    assign unused_tail = ^{div_rem[QW], div_d[QW]};

    assign o_stall     = !front_ready;
    assign o_red_out   = out_pix.red;
    assign o_green_out = out_pix.green;
    assign o_blue_out  = out_pix.blue;

endmodule

// ----- hw/rtl/ibp_checker.sv -----
module ibp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [7:0] i_red_in,
    input logic [7:0] i_green_in,
    input logic [7:0] i_blue_in,
    input logic [7:0] i_light_level,
    input logic       i_cfg_wr_en,
    input logic       i_cfg_index,
    input logic [16:0] i_cfg_wdata,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_red_out,
    input logic [7:0] o_green_out,
    input logic [7:0] o_blue_out
);

    // Reset empties the pipeline, so no transfer is offered right after it.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // With the output side free, every stage can move, so input never stalls.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || !i_stall) |-> !o_stall)
        else $error("input stalled without output backpressure");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("output valid dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            ($stable(o_red_out) && $stable(o_green_out) && $stable(o_blue_out)))
        else $error("output payload changed while stalled");

endmodule

bind illumination_brighten_pixel ibp_checker u_ibp_checker (.*);
